### rtl/ierr_pkg.sv
package ierr_pkg;

  localparam int unsigned MAPS_DEF          = 4;
  localparam int unsigned RULES_PER_MAP_DEF = 16;
  localparam int unsigned CHANNELS_DEF      = 16;

  localparam int unsigned FIELDS  = 4;
  localparam int unsigned BOUND_W = 2 + 32 + 32;
  localparam int unsigned REPL_W  = 33;
  localparam int unsigned HDR_W   = 12;

  typedef enum logic [1:0] {
    ACT_EVENT  = 2'd0,
    ACT_BOUNDS = 2'd1,
    ACT_REPL   = 2'd2,
    ACT_HEADER = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_DROP   = 3'd0,
    KIND_PASS   = 3'd1,
    KIND_SEND   = 3'd2,
    KIND_SWITCH = 3'd3,
    KIND_EXIT   = 3'd4,
    KIND_EXEC   = 3'd5
  } rule_kind_t;

  typedef enum logic [1:0] {
    OUT_EVENT = 2'd0,
    OUT_EXEC  = 2'd1,
    OUT_EXIT  = 2'd2
  } out_kind_t;

  localparam logic [1:0] CFG_START_MAP    = 2'd0;
  localparam logic [1:0] CFG_MAPS_PRESENT = 2'd1;

  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] ev_type;
    logic [15:0] ev_code;
    logic [31:0] ev_value;
  } event_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [3:0]  out_channel;
    logic [15:0] out_type;
    logic [15:0] out_code;
    logic [31:0] out_value;
    logic [7:0]  command_index;
  } result_t;

endpackage

### rtl/ierr_if.sv
interface ierr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  channel;
  logic [15:0] ev_type;
  logic [15:0] ev_code;
  logic [31:0] ev_value;
  logic [1:0]  rule_map;
  logic [3:0]  rule_slot;
  logic [1:0]  field_sel;
  logic [31:0] bound_low;
  logic [31:0] bound_high;
  logic [1:0]  bound_flags;
  logic [2:0]  rule_kind;
  modport source (output valid, action, channel, ev_type, ev_code, ev_value, rule_map,
                  rule_slot, field_sel, bound_low, bound_high, bound_flags, rule_kind,
                  input ready);
  modport sink (input valid, action, channel, ev_type, ev_code, ev_value, rule_map,
                rule_slot, field_sel, bound_low, bound_high, bound_flags, rule_kind,
                output ready);
endinterface

interface ierr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [3:0]  out_channel;
  logic [15:0] out_type;
  logic [15:0] out_code;
  logic [31:0] out_value;
  logic [7:0]  command_index;
  modport source (output valid, out_kind, out_channel, out_type, out_code, out_value,
                  command_index, input ready);
  modport sink (input valid, out_kind, out_channel, out_type, out_code, out_value,
                command_index, output ready);
endinterface

interface ierr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/ierr_ram.sv
module ierr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/ierr_front.sv
module ierr_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ierr_in_if.sink              in_ch,
  output logic                 q_valid,
  input  logic                 q_pop,
  input  logic                 back_idle,
  output ierr_pkg::event_t     q_event,
  output logic                 wr_en,
  output logic [1:0]           wr_action,
  output logic [1:0]           wr_map,
  output logic [3:0]           wr_slot,
  output logic [1:0]           wr_field,
  output logic [31:0]          wr_low,
  output logic [31:0]          wr_high,
  output logic [1:0]           wr_flags,
  output logic [2:0]           wr_kind
);
  import ierr_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  event_t        fifo_r [DEPTH];
  logic [AW-1:0] rd_r, rd_nxt, wp_r, wp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          push;
  logic          acc;

  // rule writes are taken only with the queue empty and the back idle so they stay in order
  assign in_ch.ready = (in_ch.action == ACT_EVENT) ? (cnt_r != DEPTH[AW:0])
                                                  : (cnt_r == '0 && !q_pop && back_idle);
  assign acc       = in_ch.valid && in_ch.ready;
  assign push      = acc && in_ch.action == ACT_EVENT;
  assign wr_en     = acc && in_ch.action != ACT_EVENT;
  assign wr_action = in_ch.action;
  assign wr_map    = in_ch.rule_map;
  assign wr_slot   = in_ch.rule_slot;
  assign wr_field  = in_ch.field_sel;
  assign wr_low    = in_ch.bound_low;
  assign wr_high   = in_ch.bound_high;
  assign wr_flags  = in_ch.bound_flags;
  assign wr_kind   = in_ch.rule_kind;

  assign q_valid = cnt_r != '0;
  assign q_event = fifo_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r;
    wp_nxt  = wp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt  = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      cnt_nxt = cnt_nxt + 1'b1;
    end
    if (q_pop) begin
      rd_nxt  = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      cnt_nxt = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wp_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      fifo_r[wp_r] <= '{channel: in_ch.channel, ev_type: in_ch.ev_type,
                        ev_code: in_ch.ev_code, ev_value: in_ch.ev_value};
    end
  end
endmodule

### rtl/ierr_back.sv
module ierr_back #(
  parameter int unsigned MAPS          = ierr_pkg::MAPS_DEF,
  parameter int unsigned RULES_PER_MAP = ierr_pkg::RULES_PER_MAP_DEF,
  parameter int unsigned CHANNELS      = ierr_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              idle,
  input  ierr_pkg::event_t  q_event,
  input  logic              wr_en,
  input  logic [1:0]        wr_action,
  input  logic [1:0]        wr_map,
  input  logic [3:0]        wr_slot,
  input  logic [1:0]        wr_field,
  input  logic [31:0]       wr_low,
  input  logic [31:0]       wr_high,
  input  logic [1:0]        wr_flags,
  input  logic [2:0]        wr_kind,
  ierr_cfg_if.sink          cfg_ch,
  ierr_out_if.source        out_ch
);
  import ierr_pkg::*;

  localparam int unsigned SLOTS = MAPS * RULES_PER_MAP;
  localparam int unsigned RW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SW    = (RULES_PER_MAP > 1) ? $clog2(RULES_PER_MAP) : 1;
  localparam int unsigned EW    = RW + 2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_REPL  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       cur_map_r;
  logic [3:0]       present_r;
  logic             halted_r;
  logic [SLOTS-1:0] hvalid_r;
  logic             hvalid_q_r;
  logic [SW-1:0]    slot_r;
  logic [1:0]       fld_r;
  logic             ok_r;
  event_t           ev_r;
  result_t          res_r;
  result_t          obuf_r;
  logic             ovalid_r;
  logic [RW-1:0]    rule_idx;
  logic [RW-1:0]    wr_rule;
  logic             wr_ok;

  logic             b_we, r_we, h_we;
  logic [EW-1:0]    waddr, raddr;
  logic [BOUND_W-1:0] b_rdata;
  logic [REPL_W-1:0]  r_rdata;
  logic [HDR_W-1:0]   h_rdata;

  logic signed [32:0] fv;
  logic signed [32:0] lo, hi;
  logic               fld_in;
  logic [HDR_W-1:0]   hdr;
  logic               last_slot;
  logic               map_ok;
  logic [7:0]         arg;

  assign wr_ok   = (32'(wr_map) < MAPS) && (32'(wr_slot) < RULES_PER_MAP);
  assign wr_rule = RW'(32'(wr_map) * RULES_PER_MAP + 32'(wr_slot));
  assign waddr   = {wr_rule, wr_field};
  assign b_we    = wr_en && wr_ok && wr_action == ACT_BOUNDS;
  assign r_we    = wr_en && wr_ok && wr_action == ACT_REPL;
  assign h_we    = wr_en && wr_ok && wr_action == ACT_HEADER;
  assign rule_idx = RW'(32'(cur_map_r) * RULES_PER_MAP + 32'(slot_r));
  assign raddr    = {rule_idx, fld_r};
  assign map_ok   = 32'(cur_map_r) < MAPS;
  assign last_slot = 32'(slot_r) == RULES_PER_MAP - 1;
  assign hdr = hvalid_q_r ? h_rdata : '0;
  assign arg = hdr[7:0];

  ierr_ram #(.WIDTH(BOUND_W), .DEPTH(SLOTS * FIELDS)) u_bound (
    .clk, .we(b_we), .waddr, .wdata({wr_flags, wr_low, wr_high}),
    .raddr, .rdata(b_rdata));
  ierr_ram #(.WIDTH(REPL_W), .DEPTH(SLOTS * FIELDS)) u_repl (
    .clk, .we(r_we), .waddr, .wdata({wr_flags[0], wr_low}),
    .raddr, .rdata(r_rdata));
  ierr_ram #(.WIDTH(HDR_W), .DEPTH(SLOTS)) u_hdr (
    .clk, .we(h_we), .waddr(wr_rule), .wdata({wr_flags[0], wr_kind, wr_low[7:0]}),
    .raddr(rule_idx), .rdata(h_rdata));

  always_comb begin
    unique case (fld_r)
      2'd0:    fv = 33'(ev_r.channel);
      2'd1:    fv = 33'(ev_r.ev_type);
      2'd2:    fv = 33'(ev_r.ev_code);
      default: fv = {ev_r.ev_value[31], ev_r.ev_value};
    endcase
    lo = {b_rdata[63], b_rdata[63:32]};
    hi = {b_rdata[31], b_rdata[31:0]};
    fld_in = !((b_rdata[64] && lo > fv) || (b_rdata[65] && fv > hi));
  end

  assign cfg_ch.ready = 1'b1;
  assign idle  = state_r == ST_IDLE;
  assign q_pop = state_r == ST_IDLE && q_valid;
  assign out_ch.valid = ovalid_r;
  assign out_ch.out_kind = obuf_r.out_kind;
  assign out_ch.out_channel = obuf_r.out_channel;
  assign out_ch.out_type = obuf_r.out_type;
  assign out_ch.out_code = obuf_r.out_code;
  assign out_ch.out_value = obuf_r.out_value;
  assign out_ch.command_index = obuf_r.command_index;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = ST_READ;
      ST_REPL:  state_nxt = ST_OUT;
      ST_OUT:   if (!ovalid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_map_r  <= '0;
      present_r  <= 4'd1;
      halted_r   <= 1'b0;
      hvalid_r   <= '0;
      hvalid_q_r <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      hvalid_q_r <= hvalid_r[rule_idx];
      if (state_r == ST_OUT && (!ovalid_r || out_ch.ready)) begin
        ovalid_r <= 1'b1;
        obuf_r   <= res_r;
      end else if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_START_MAP:    cur_map_r <= cfg_ch.data[1:0];
          CFG_MAPS_PRESENT: present_r <= cfg_ch.data[3:0];
          default: ;
        endcase
      end
      if (h_we) begin
        hvalid_r[wr_rule] <= 1'b1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            ev_r   <= q_event;
            slot_r <= '0;
            fld_r  <= '0;
            ok_r   <= 1'b1;
            if (halted_r || 32'(q_event.channel) >= CHANNELS) state_r <= ST_IDLE;
            else if (!map_ok) begin
              res_r <= '{out_kind: OUT_EVENT, out_channel: q_event.channel,
                         out_type: q_event.ev_type, out_code: q_event.ev_code,
                         out_value: q_event.ev_value, command_index: 8'd0};
              state_r <= ST_OUT;
            end else state_r <= state_nxt;
          end
        end
        ST_READ: state_r <= state_nxt;
        ST_CHECK: begin
          if (fld_r != 2'd3 && ok_r && fld_in && hdr[11]) begin
            fld_r   <= fld_r + 1'b1;
            state_r <= ST_READ;
          end else if (hdr[11] && ok_r && fld_in) begin
            fld_r <= '0;
            res_r <= '{out_kind: OUT_EVENT, out_channel: ev_r.channel,
                       out_type: ev_r.ev_type, out_code: ev_r.ev_code,
                       out_value: ev_r.ev_value, command_index: 8'd0};
            unique case (hdr[10:8])
              KIND_DROP: state_r <= ST_IDLE;
              KIND_SEND: state_r <= ST_REPL;
              KIND_SWITCH: begin
                if (32'(arg) < MAPS && arg < 8'd4 && present_r[arg[1:0]])
                  cur_map_r <= arg[1:0];
                state_r <= ST_IDLE;
              end
              KIND_EXIT: begin
                halted_r <= 1'b1;
                res_r <= '{out_kind: OUT_EXIT, default: '0};
                state_r <= ST_OUT;
              end
              KIND_EXEC: begin
                res_r <= '{out_kind: OUT_EXEC, command_index: arg, default: '0};
                state_r <= ST_OUT;
              end
              default: state_r <= ST_OUT;
            endcase
          end else if (last_slot) begin
            res_r <= '{out_kind: OUT_EVENT, out_channel: ev_r.channel,
                       out_type: ev_r.ev_type, out_code: ev_r.ev_code,
                       out_value: ev_r.ev_value, command_index: 8'd0};
            state_r <= ST_OUT;
          end else begin
            slot_r  <= slot_r + 1'b1;
            fld_r   <= '0;
            state_r <= ST_READ;
          end
        end
        ST_REPL: begin
          // read data comes from a registered read, so it belongs to the previous field
          if (r_rdata[32]) begin
            unique case (fld_r - 2'd1)
              2'd0:    res_r.out_channel <= r_rdata[3:0];
              2'd1:    res_r.out_type    <= r_rdata[15:0];
              2'd2:    res_r.out_code    <= r_rdata[15:0];
              default: res_r.out_value   <= r_rdata[31:0];
            endcase
          end
          if (fld_r == 2'd3) state_r <= ST_OUT;
          fld_r <= fld_r + 1'b1;
        end
        ST_OUT: begin
          if (!ovalid_r || out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

### rtl/input_event_rule_remapper.sv
// channel | dir | transaction
// in_     | in  | event or rule write (action selects)
// out_    | out | emitted event, exec request or exit
// cfg_    | in  | register write, index 0 start_map, 1 maps_present
// an event is popped, then read and checked field by field (up to 4 fields per slot
// over 16 slots); a send rewrites the fields and the output register is loaded last;
// the scan is bounded by the single read port of the rule memories
// synchronous reset invalidates rule headers and clears current map and halt at once
// events queue in front while the back scans; rule writes wait for an empty queue
// and an idle back; a waiting result stalls the back only when a second one is ready
module input_event_rule_remapper #(
  parameter int unsigned MAPS          = ierr_pkg::MAPS_DEF,
  parameter int unsigned RULES_PER_MAP = ierr_pkg::RULES_PER_MAP_DEF,
  parameter int unsigned CHANNELS      = ierr_pkg::CHANNELS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ierr_in_if.sink     in_ch,
  ierr_out_if.source  out_ch,
  ierr_cfg_if.sink    cfg_ch
);
  import ierr_pkg::*;

  logic        q_valid, q_pop, wr_en, back_idle;
  event_t      q_event;
  logic [1:0]  wr_action, wr_map, wr_field, wr_flags;
  logic [3:0]  wr_slot;
  logic [31:0] wr_low, wr_high;
  logic [2:0]  wr_kind;

  ierr_front #(.DEPTH(4)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_pop, .back_idle, .q_event, .wr_en, .wr_action,
    .wr_map, .wr_slot, .wr_field, .wr_low, .wr_high, .wr_flags, .wr_kind);

  ierr_back #(.MAPS(MAPS), .RULES_PER_MAP(RULES_PER_MAP), .CHANNELS(CHANNELS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .idle(back_idle), .q_event, .wr_en, .wr_action,
    .wr_map, .wr_slot, .wr_field, .wr_low, .wr_high, .wr_flags, .wr_kind, .cfg_ch,
    .out_ch);
endmodule
